[rtl/lbpbp_pkg.sv]
// ----------------------------------------------------------------------------
// lbpbp_pkg : shared types and constants of the LBP border-pad block
// Holds the register indexes, the burst slot numbering and the job word that
// passes from the front end to the write sequencer.
// ----------------------------------------------------------------------------
package lbpbp_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH  = 4;
   localparam int unsigned CSR_DATA_WIDTH   = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT = 4'd1;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam int unsigned ROW_WIDTH  = 12;
   localparam int unsigned COL_WIDTH  = 11;
   localparam int unsigned PIX_WIDTH  = 8;

   // Depth of the job queue between front end and sequencer.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_WIDTH  = 2;
   localparam int unsigned QCNT_WIDTH  = 3;

   // Slots of one write burst, in the order in which they leave.
   localparam int unsigned BURST_SLOTS  = 9;
   localparam int unsigned SLOT_CENTRE  = 0;
   localparam int unsigned SLOT_TOP     = 1;
   localparam int unsigned SLOT_BOTTOM  = 2;
   localparam int unsigned SLOT_LEFT    = 3;
   localparam int unsigned SLOT_RIGHT   = 4;
   localparam int unsigned SLOT_TL      = 5;
   localparam int unsigned SLOT_TR      = 6;
   localparam int unsigned SLOT_BL      = 7;
   localparam int unsigned SLOT_BR      = 8;

   typedef logic [BURST_SLOTS-1:0] burst_mask_type;

   // One centre code with everything the sequencer needs to expand it.
   typedef struct packed {
      logic [ROW_WIDTH-1:0] row;
      logic [COL_WIDTH-1:0] col;
      logic [PIX_WIDTH-1:0] code;
      logic                 top;
      logic                 bottom;
      logic                 left;
      logic                 right;
      logic [ROW_WIDTH-1:0] row_last;
      logic [COL_WIDTH-1:0] col_last;
   } job_type;

endpackage

[rtl/lbpbp_front.sv]
// ----------------------------------------------------------------------------
// lbpbp_front : pixel intake, line stores, window and code forming
// Accepts pixels, keeps the raster position, two line stores and the 3x3
// window, and hands one job per interior centre to the job queue.
// ----------------------------------------------------------------------------
module lbpbp_front
   import lbpbp_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic [PIX_WIDTH-1:0]       req_pixel,
   output logic                       req_full,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic [QCNT_WIDTH-1:0]      queue_count,
   output logic                       job_push,
   output job_type                    job
);

   localparam int unsigned CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
   localparam int unsigned WBITS = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

   logic [11:0]          frame_width_ff, frame_width_in;
   logic [11:0]          frame_height_ff, frame_height_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_WIDTH-1:0] row_ff, row_in;

   logic [PIX_WIDTH-1:0] store_a [MAX_WIDTH];
   logic [PIX_WIDTH-1:0] store_b [MAX_WIDTH];
   logic [PIX_WIDTH-1:0] above2_ff, above1_ff;

   logic                 s1_valid_ff, s1_emit_ff;
   logic [PIX_WIDTH-1:0] s1_px_ff;
   logic [CW-1:0]        s1_col_ff;
   logic [ROW_WIDTH-1:0] s1_row_ff;

   logic [PIX_WIDTH-1:0] win_ff [3][3];

   logic                 s2_valid_ff;
   logic [ROW_WIDTH-1:0] s2_row_ff;
   logic [COL_WIDTH-1:0] s2_col_ff;
   logic                 s2_top_ff, s2_bottom_ff, s2_left_ff, s2_right_ff;

   logic [WBITS-1:0]     eff_width;
   logic [ROW_WIDTH-1:0] eff_height;
   logic [CW-1:0]        col_last, col_minus2;
   logic [ROW_WIDTH-1:0] row_last, row_minus2;
   logic                 degenerate, accept, cfg_hit;
   logic [CW-1:0]        s1_centre_col;
   logic [ROW_WIDTH-1:0] s1_centre_row;
   logic [QCNT_WIDTH-1:0] committed;
   logic [PIX_WIDTH-1:0] centre;
   logic [PIX_WIDTH-1:0] code;

   // Clamped frame size and the compare values derived from it.
   always_comb begin
      if (WBITS'(frame_width_ff) > WBITS'(MAX_WIDTH)) begin
         eff_width = WBITS'(MAX_WIDTH);
      end else if (frame_width_ff < 12'd3) begin
         eff_width = WBITS'(3);
      end else begin
         eff_width = WBITS'(frame_width_ff);
      end
      if (frame_height_ff < 12'd3) begin
         eff_height = 12'd3;
      end else begin
         eff_height = frame_height_ff;
      end
      col_last   = CW'(eff_width - WBITS'(1));
      col_minus2 = CW'(eff_width - WBITS'(2));
      row_last   = eff_height - 12'd1;
      row_minus2 = eff_height - 12'd2;
      degenerate = (frame_width_ff < 12'd3) || (frame_height_ff < 12'd3);
   end

   // Every pixel in the two pipeline stages may still push a job, so it is
   // counted against the free queue space before the next one is taken.
   assign committed = queue_count + QCNT_WIDTH'(s1_valid_ff) + QCNT_WIDTH'(s2_valid_ff);
   assign req_full  = committed >= QCNT_WIDTH'(QUEUE_DEPTH);
   assign accept    = req_push && !req_full;
   assign cfg_hit   = csr_valid && ((csr_index == CSR_FRAME_WIDTH) ||
                                    (csr_index == CSR_FRAME_HEIGHT));

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (cfg_hit) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_in = csr_wdata;
         end else begin
            frame_height_in = csr_wdata;
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= accept;
         s2_valid_ff     <= s1_valid_ff && s1_emit_ff;
      end
   end

   // Line stores: read both at the pixel's column; row r-1 moves down into
   // the older store in the next cycle, when its read data is at hand.
   always_ff @(posedge clock) begin
      if (accept) begin
         above2_ff         <= store_a[col_ff];
         above1_ff         <= store_b[col_ff];
         store_b[col_ff]   <= req_pixel;
      end
      if (s1_valid_ff) begin
         store_a[s1_col_ff] <= above1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_pixel;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_emit_ff <= !degenerate && (row_ff >= 12'd2) && (col_ff >= CW'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= above2_ff;
         win_ff[1][2] <= above1_ff;
         win_ff[2][2] <= s1_px_ff;
      end
   end

   assign s1_centre_col = s1_col_ff - CW'(1);
   assign s1_centre_row = s1_row_ff - 12'd1;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_row_ff    <= s1_centre_row;
         s2_col_ff    <= COL_WIDTH'(s1_centre_col);
         s2_top_ff    <= s1_centre_row == 12'd1;
         s2_bottom_ff <= s1_centre_row == row_minus2;
         s2_left_ff   <= s1_centre_col == CW'(1);
         s2_right_ff  <= s1_centre_col == col_minus2;
      end
   end

   // Neighbours clockwise from the top left.
   always_comb begin
      centre  = win_ff[1][1];
      code[0] = centre > win_ff[0][0];
      code[1] = centre > win_ff[0][1];
      code[2] = centre > win_ff[0][2];
      code[3] = centre > win_ff[1][2];
      code[4] = centre > win_ff[2][2];
      code[5] = centre > win_ff[2][1];
      code[6] = centre > win_ff[2][0];
      code[7] = centre > win_ff[1][0];
   end

   assign job_push     = s2_valid_ff;
   assign job.row      = s2_row_ff;
   assign job.col      = s2_col_ff;
   assign job.code     = code;
   assign job.top      = s2_top_ff;
   assign job.bottom   = s2_bottom_ff;
   assign job.left     = s2_left_ff;
   assign job.right    = s2_right_ff;
   assign job.row_last = row_last;
   assign job.col_last = COL_WIDTH'(eff_width - WBITS'(1));

endmodule

[rtl/lbpbp_queue.sv]
// ----------------------------------------------------------------------------
// lbpbp_queue : short job queue
// A small first-in first-out store of jobs with its head always visible.
// ----------------------------------------------------------------------------
module lbpbp_queue
   import lbpbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  job_type               push_job,
   input  logic                  pop,
   output job_type               head,
   output logic                  empty,
   output logic [QCNT_WIDTH-1:0] count
);

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         end
         count_ff <= count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
      end
   end

endmodule

[rtl/lbpbp_back.sv]
// ----------------------------------------------------------------------------
// lbpbp_back : write burst sequencer
// Expands each job into its centre write and border copies into a
// registered result stage, one word per cycle unless that stage is held.
// ----------------------------------------------------------------------------
module lbpbp_back
   import lbpbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  job_type              head,
   input  logic                 queue_empty,
   output logic                 queue_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [ROW_WIDTH-1:0] rsp_out_row,
   output logic [COL_WIDTH-1:0] rsp_out_col,
   output logic [PIX_WIDTH-1:0] rsp_code,
   output logic                 rsp_last
);

   job_type              job_ff, job_in;
   burst_mask_type       mask_ff, mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_WIDTH-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_WIDTH-1:0] rsp_col_ff, rsp_col_in;
   logic [PIX_WIDTH-1:0] rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   burst_mask_type       sel, rest, head_mask;
   logic                 out_free, emit, job_done;
   logic [ROW_WIDTH-1:0] sel_row;
   logic [COL_WIDTH-1:0] sel_col;

   always_comb begin
      head_mask              = '0;
      head_mask[SLOT_CENTRE] = 1'b1;
      head_mask[SLOT_TOP]    = head.top;
      head_mask[SLOT_BOTTOM] = head.bottom;
      head_mask[SLOT_LEFT]   = head.left;
      head_mask[SLOT_RIGHT]  = head.right;
      head_mask[SLOT_TL]     = head.top && head.left;
      head_mask[SLOT_TR]     = head.top && head.right;
      head_mask[SLOT_BL]     = head.bottom && head.left;
      head_mask[SLOT_BR]     = head.bottom && head.right;
   end

   // Lowest pending slot goes first; that matches the burst order.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_pop;
      emit     = out_free && (mask_ff != '0);
      sel      = mask_ff & (~mask_ff + BURST_SLOTS'(1));
      rest     = mask_ff & ~sel;
      job_done = (mask_ff == '0) || (emit && (rest == '0));
      queue_pop = job_done && !queue_empty;
   end

   always_comb begin
      sel_row = job_ff.row;
      sel_col = job_ff.col;
      if (sel[SLOT_TOP]) begin
         sel_row = '0;
      end else if (sel[SLOT_BOTTOM]) begin
         sel_row = job_ff.row_last;
      end else if (sel[SLOT_LEFT]) begin
         sel_col = '0;
      end else if (sel[SLOT_RIGHT]) begin
         sel_col = job_ff.col_last;
      end else if (sel[SLOT_TL]) begin
         sel_row = '0;
         sel_col = '0;
      end else if (sel[SLOT_TR]) begin
         sel_row = '0;
         sel_col = job_ff.col_last;
      end else if (sel[SLOT_BL]) begin
         sel_row = job_ff.row_last;
         sel_col = '0;
      end else if (sel[SLOT_BR]) begin
         sel_row = job_ff.row_last;
         sel_col = job_ff.col_last;
      end
   end

   always_comb begin
      job_in  = job_ff;
      mask_in = emit ? rest : mask_ff;
      if (queue_pop) begin
         job_in  = head;
         mask_in = head_mask;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = sel_row;
         rsp_col_in   = sel_col;
         rsp_code_in  = job_ff.code;
         rsp_last_in  = rest == '0;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_code    = rsp_code_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

[rtl/lbp_3x3_with_border_pad.sv]
// ----------------------------------------------------------------------------
// lbp_3x3_with_border_pad : 3x3 local binary pattern with border padding
// Streams a raster-order grey image and writes an 8-neighbour pattern for
// every pixel of the output image, the border copied from its inner row or
// column.
// ----------------------------------------------------------------------------
// Pixels are pushed in raster order, one word per pixel, and for every
// interior centre the block emits an addressed write of row, column and
// code, followed by the copies that pad the border rows, border columns and
// corners, with last set on the final word of each burst. The front end
// takes one pixel per cycle while full is low; its two line stores are
// single-port reads at the pixel's column, so there is no per-pixel loop.
// Result words leave through a single registered port at one word per cycle
// while the receiver pops. A pixel causes one write in the body of the image,
// two along the top and bottom rows and the left and right columns, four at
// a corner (nine for a 3x3 image); that port sets the sustained rate. A
// four-entry job queue lets the front end run ahead of the write sequencer,
// and full is raised when queued jobs plus pixels still in the two front
// stages would fill it. A pixel's first result word passes the two front
// stages, the job queue, the job register and the result register. The
// line stores are not cleared after reset; their contents are only read for
// rows that produce no output. Configuration writes (frame_width at index 0,
// frame_height at index 1) take effect at once and restart the frame at
// row 0, column 0; they must only be made while the block is idle. Writes
// to other indexes are accepted and ignored.
// ----------------------------------------------------------------------------
module lbp_3x3_with_border_pad
   import lbpbp_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic [PIX_WIDTH-1:0]       req_pixel,
   output logic                       req_full,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [ROW_WIDTH-1:0]       rsp_out_row,
   output logic [COL_WIDTH-1:0]       rsp_out_col,
   output logic [PIX_WIDTH-1:0]       rsp_code,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   job_type               front_job;
   job_type               queue_head;
   logic                  job_push;
   logic                  queue_pop;
   logic                  queue_empty;
   logic [QCNT_WIDTH-1:0] queue_count;

   // Registers are always writable; the port never stalls.
   assign csr_ready = 1'b1;

   // Front end: position counters, line stores, window and code forming.
   lbpbp_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_pixel   (req_pixel),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_count (queue_count),
      .job_push    (job_push),
      .job         (front_job)
   );

   // Jobs wait here so that a long border burst does not stall intake at once.
   lbpbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (queue_pop),
      .head     (queue_head),
      .empty    (queue_empty),
      .count    (queue_count)
   );

   // Write sequencer: one result word per cycle into the output register, when it is free.
   lbpbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (queue_head),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_code    (rsp_code),
      .rsp_last    (rsp_last)
   );

endmodule

[sim/lbp_3x3_with_border_pad_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbp_3x3_with_border_pad_tb : self-checking bench for the LBP border-pad block
// Streams grey images of many sizes through the block and checks every
// padded write against a cycle-free predictor of the 3x3 pattern and its
// border copies, with random bursts on the pixel side and stalls on the
// result side.
// ----------------------------------------------------------------------------
module lbp_3x3_with_border_pad_tb
   import lbpbp_pkg::*;
();

   localparam int unsigned MAX_W       = 2048;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   // Pixels that cause no write may still be in flight when the last
   // expected word has left, so the bench lets this many cycles pass before
   // touching the registers or ending the run.
   localparam int unsigned SETTLE_CYCLES = 20;
   // Pixels streamed by the random part; with the directed frames the run
   // comes to about 310 pixels.
   localparam int unsigned RANDOM_PIXELS = 277;

   // One addressed write as it leaves the result port.
   typedef struct packed {
      logic [ROW_WIDTH-1:0] row;
      logic [COL_WIDTH-1:0] col;
      logic [PIX_WIDTH-1:0] code;
      logic                 last;
   } lbp_write_type;

   typedef enum int unsigned {
      PIX_FULL,
      PIX_NARROW,
      PIX_EXTREME
   } pix_mode_type;

   // Clock, reset and block ports. Every input holds a known value from
   // time zero.
   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_push  = 1'b0;
   logic [PIX_WIDTH-1:0]       req_pixel = '0;
   logic                       req_full;
   logic                       rsp_pop   = 1'b0;
   logic                       rsp_empty;
   logic [ROW_WIDTH-1:0]       rsp_out_row;
   logic [COL_WIDTH-1:0]       rsp_out_col;
   logic [PIX_WIDTH-1:0]       rsp_code;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Predictor state: its own copy of the frame size, the two line stores,
   // the 3x3 window and the raster position.
   logic [CSR_DATA_WIDTH-1:0]  cfg_width;
   logic [CSR_DATA_WIDTH-1:0]  cfg_height;
   logic [PIX_WIDTH-1:0]       row_above2 [MAX_W];
   logic [PIX_WIDTH-1:0]       row_above1 [MAX_W];
   logic [PIX_WIDTH-1:0]       lbp_win    [3][3];
   int unsigned                pos_row;
   int unsigned                pos_col;

   // Pixels waiting to be offered, and writes the block still owes us.
   logic [PIX_WIDTH-1:0]       pixel_backlog [$];
   lbp_write_type              predicted_writes [$];

   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int unsigned pixels_taken  = 0;
   int unsigned writes_seen   = 0;
   int unsigned csr_writes    = 0;

   // Sender burst state and receiver stall pattern.
   int unsigned burst_left    = 0;
   int unsigned gap_left      = 0;
   int unsigned stall_mode    = 0;
   int unsigned stall_phase   = 0;

   lbp_3x3_with_border_pad #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_pixel   (req_pixel),
      .req_full    (req_full),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_code    (rsp_code),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every mismatch goes through here: one line each, and it is counted.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      $display("MISMATCH cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
   endtask

   function automatic lbp_write_type make_write(input int unsigned row,
                                                input int unsigned col,
                                                input logic [PIX_WIDTH-1:0] code);
      lbp_write_type w;
      w.row  = row[ROW_WIDTH-1:0];
      w.col  = col[COL_WIDTH-1:0];
      w.code = code;
      w.last = 1'b0;
      return w;
   endfunction

   // A register write restarts the frame at the top left; the line stores
   // and the window keep their contents. Unused indexes change nothing.
   task automatic apply_frame_size(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [CSR_DATA_WIDTH-1:0] data);
      if (idx == CSR_FRAME_WIDTH) begin
         cfg_width = data;
         pos_row   = 0;
         pos_col   = 0;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         cfg_height = data;
         pos_row    = 0;
         pos_col    = 0;
      end
   endtask

   // Takes one accepted pixel through the line stores and the window and
   // queues the burst of writes it causes, centre first, then the top or
   // bottom copy, the left or right copy, and finally the corners.
   task automatic predict_lbp_writes(input logic [PIX_WIDTH-1:0] px);
      int unsigned          w;
      int unsigned          h;
      int unsigned          r;
      int unsigned          c;
      int unsigned          cr;
      int unsigned          cc;
      int unsigned          n;
      bit                   degenerate;
      bit                   top;
      bit                   bottom;
      bit                   left;
      bit                   right;
      logic [PIX_WIDTH-1:0] up2;
      logic [PIX_WIDTH-1:0] up1;
      logic [PIX_WIDTH-1:0] v;
      logic [PIX_WIDTH-1:0] code;
      lbp_write_type        burst [BURST_SLOTS];

      w = cfg_width;
      h = cfg_height;
      // A frame narrower or shorter than three still counts positions as
      // if it were three, but it never writes anything.
      degenerate = (w < 3) || (h < 3);
      if (w > MAX_W) w = MAX_W;
      if (w < 3) w = 3;
      if (h < 3) h = 3;
      if (pos_col >= w) pos_col = 0;
      if (pos_row >= h) pos_row = 0;
      r = pos_row;
      c = pos_col;

      up2 = row_above2[c % MAX_W];
      up1 = row_above1[c % MAX_W];
      row_above2[c % MAX_W] = up1;
      row_above1[c % MAX_W] = px;

      for (int i = 0; i < 3; i++) begin
         lbp_win[i][0] = lbp_win[i][1];
         lbp_win[i][1] = lbp_win[i][2];
      end
      lbp_win[0][2] = up2;
      lbp_win[1][2] = up1;
      lbp_win[2][2] = px;

      if (!degenerate && r >= 2 && c >= 2) begin
         cr = r - 1;
         cc = c - 1;
         v  = lbp_win[1][1];
         // Bit k compares against neighbour k, clockwise from top left.
         code = {v > lbp_win[1][0], v > lbp_win[2][0], v > lbp_win[2][1],
                 v > lbp_win[2][2], v > lbp_win[1][2], v > lbp_win[0][2],
                 v > lbp_win[0][1], v > lbp_win[0][0]};
         top    = (cr == 1);
         bottom = (cr == h - 2);
         left   = (cc == 1);
         right  = (cc == w - 2);

         n = 0;
         burst[n] = make_write(cr, cc, code);
         n++;
         if (top) begin
            burst[n] = make_write(0, cc, code);
            n++;
         end
         if (bottom) begin
            burst[n] = make_write(h - 1, cc, code);
            n++;
         end
         if (left) begin
            burst[n] = make_write(cr, 0, code);
            n++;
         end
         if (right) begin
            burst[n] = make_write(cr, w - 1, code);
            n++;
         end
         if (top && left) begin
            burst[n] = make_write(0, 0, code);
            n++;
         end
         if (top && right) begin
            burst[n] = make_write(0, w - 1, code);
            n++;
         end
         if (bottom && left) begin
            burst[n] = make_write(h - 1, 0, code);
            n++;
         end
         if (bottom && right) begin
            burst[n] = make_write(h - 1, w - 1, code);
            n++;
         end
         burst[n-1].last = 1'b1;
         for (int i = 0; i < n; i++)
            predicted_writes.push_back(burst[i]);
      end

      pos_col = c + 1;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row = r + 1;
         if (pos_row >= h) pos_row = 0;
      end
   endtask

   // Pixel driver. A word is taken at an edge with push high and full low;
   // the next word is then put up straight away unless a gap is due. The
   // sender works in bursts of random length separated by random gaps,
   // with a fair share of zero-length gaps so that long unbroken stretches
   // occur as well.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_lbp_writes(req_pixel);
            pixels_taken++;
         end
         if (!req_push || !req_full) begin
            if (gap_left != 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               req_push  <= 1'b1;
               req_pixel <= pixel_backlog.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each word popped is compared field by field with the
   // oldest predicted write. The receiver keeps switching between randomly
   // chosen stall patterns: no stalls, random stalls, a fixed duty cycle, or long
   // back-pressure stretches that let the job queue fill up.
   always @(posedge clock) begin
      lbp_write_type want;
      bit            pop_next;

      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            writes_seen++;
            if (predicted_writes.size() == 0) begin
               report_mismatch("unexpected write at row", rsp_out_row, 0);
            end else begin
               want = predicted_writes.pop_front();
               if (rsp_out_row !== want.row)
                  report_mismatch("out_row", rsp_out_row, want.row);
               if (rsp_out_col !== want.col)
                  report_mismatch("out_col", rsp_out_col, want.col);
               if (rsp_code !== want.code)
                  report_mismatch("code", rsp_code, want.code);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end

         if (stall_phase % 256 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: begin
               pop_next = 1'b1;
            end
            1: begin
               pop_next = ($urandom_range(0, 2) != 0);
            end
            2: begin
               pop_next = (stall_phase % 5 < 2);
            end
            default: begin
               pop_next = (stall_phase % 40 >= 12);
            end
         endcase
         stall_phase++;
         rsp_pop <= pop_next;
      end
   end

   // Watchdog: a hung block or a lost word ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d writes still owed",
                  cycle_count, predicted_writes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Register write over the configuration channel. Valid always drops between
   // two writes, with a random gap before each one.
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      repeat ($urandom_range(1, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      apply_frame_size(idx, data);
      csr_writes++;
   endtask

   // Waits until every pixel has been taken and every write has come out,
   // then lets the tail of the pipeline settle.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (pixel_backlog.size() != 0 || req_push || predicted_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIX_WIDTH-1:0] gen_pixel(input pix_mode_type mode,
                                                      input logic [PIX_WIDTH-1:0] base);
      logic [PIX_WIDTH-1:0] p;
      case (mode)
         PIX_NARROW: begin
            // A narrow band gives plenty of equal neighbours, which must
            // not set their bit.
            p = base + PIX_WIDTH'($urandom_range(0, 2));
         end
         PIX_EXTREME: begin
            p = $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            p = PIX_WIDTH'($urandom);
         end
      endcase
      return p;
   endfunction

   // One phase: set the frame size while the block is idle, stream the
   // pixels, and wait for everything to drain.
   task automatic run_phase(input int unsigned w, input int unsigned h,
                            input int unsigned n_pix, input bit width_only);
      pix_mode_type         mode;
      logic [PIX_WIDTH-1:0] base;
      logic [CSR_INDEX_WIDTH-1:0] spare;

      if (width_only) begin
         csr_write(CSR_FRAME_WIDTH, w[CSR_DATA_WIDTH-1:0]);
      end else if ($urandom_range(0, 1)) begin
         csr_write(CSR_FRAME_WIDTH, w[CSR_DATA_WIDTH-1:0]);
         csr_write(CSR_FRAME_HEIGHT, h[CSR_DATA_WIDTH-1:0]);
      end else begin
         csr_write(CSR_FRAME_HEIGHT, h[CSR_DATA_WIDTH-1:0]);
         csr_write(CSR_FRAME_WIDTH, w[CSR_DATA_WIDTH-1:0]);
      end
      // Now and then a write to an index that has no register; the block
      // must take it and change nothing, the frame position included.
      if ($urandom_range(0, 4) == 0) begin
         spare = CSR_INDEX_WIDTH'($urandom_range(CSR_FRAME_HEIGHT + 1,
                                                 (1 << CSR_INDEX_WIDTH) - 1));
         csr_write(spare, CSR_DATA_WIDTH'($urandom));
      end

      case ($urandom_range(0, 5))
         0, 1:    mode = PIX_NARROW;
         2:       mode = PIX_EXTREME;
         default: mode = PIX_FULL;
      endcase
      base = PIX_WIDTH'($urandom);
      for (int i = 0; i < n_pix; i++)
         pixel_backlog.push_back(gen_pixel(mode, base));
      wait_idle();
   endtask

   // Hand-made 3x3 frames: a bright centre on black, a dark centre on
   // white, and a centre with neighbours one above, equal and one below.
   logic [PIX_WIDTH-1:0] frame_bright [9] = '{8'd0, 8'd0, 8'd0,
                                              8'd0, 8'd255, 8'd0,
                                              8'd0, 8'd0, 8'd0};
   logic [PIX_WIDTH-1:0] frame_dark   [9] = '{8'd255, 8'd255, 8'd255,
                                              8'd255, 8'd0, 8'd255,
                                              8'd255, 8'd255, 8'd255};
   logic [PIX_WIDTH-1:0] frame_close  [9] = '{8'd127, 8'd128, 8'd129,
                                              8'd255, 8'd128, 8'd127,
                                              8'd0, 8'd129, 8'd128};

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned random_pixels;
      int unsigned phase;

      cfg_width  = FRAME_WIDTH_RESET;
      cfg_height = FRAME_HEIGHT_RESET;
      pos_row    = 0;
      pos_col    = 0;
      for (int i = 0; i < MAX_W; i++) begin
         row_above2[i] = '0;
         row_above1[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            lbp_win[i][j] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A few pixels at the reset size of 640 by 480 reach
      // nothing below row 0, so no write may appear.
      for (int i = 0; i < 6; i++)
         pixel_backlog.push_back(PIX_WIDTH'($urandom));
      wait_idle();

      // The smallest frame: its single centre fills all nine slots of the
      // burst. The frames follow each other through the wrap at frame end.
      csr_write(CSR_FRAME_WIDTH, 12'd3);
      csr_write(CSR_FRAME_HEIGHT, 12'd3);
      for (int i = 0; i < 9; i++)
         pixel_backlog.push_back(frame_bright[i]);
      for (int i = 0; i < 9; i++)
         pixel_backlog.push_back(frame_dark[i]);
      for (int i = 0; i < 9; i++)
         pixel_backlog.push_back(frame_close[i]);
      wait_idle();

      // Random part. The first three phases take in the sizes that the
      // block has to cope with but that give no ordinary output: a width
      // below three, a height below three, and a width beyond the line
      // store, which is clamped.
      random_pixels = 0;
      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (phase == 0) begin
            run_phase($urandom_range(0, 2), $urandom_range(3, 6), 12, 1'b0);
            random_pixels += 12;
         end else if (phase == 1) begin
            run_phase($urandom_range(3, 6), $urandom_range(0, 2), 12, 1'b0);
            random_pixels += 12;
         end else if (phase == 2) begin
            run_phase($urandom_range(MAX_W + 1, 4095), $urandom_range(3, 9), 20, 1'b0);
            random_pixels += 20;
         end else begin
            case ($urandom_range(0, 9))
               0:          w = $urandom_range(25, 64);
               1, 2:       w = $urandom_range(9, 24);
               default:    w = $urandom_range(3, 8);
            endcase
            h = $urandom_range(3, 7);
            // Half the phases stream one or two whole frames, cut at 120 pixels, so
            // that borders and corners are reached; the rest stop at a random point.
            if ($urandom_range(0, 1))
               n = w * h * $urandom_range(1, 2);
            else
               n = $urandom_range(1, w * h + w);
            if (n > 120) n = 120;
            if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
            if ($urandom_range(0, 4) == 0)
               run_phase(w, cfg_height, n, 1'b1);
            else
               run_phase(w, h, n, 1'b0);
            random_pixels += n;
         end
         phase++;
      end

      if (predicted_writes.size() != 0)
         report_mismatch("writes never delivered", 0, predicted_writes.size());

      $display("Run covered %0d pixels, %0d checked writes and %0d register writes,",
               pixels_taken, writes_seen, csr_writes);
      $display("over frames from 3x3 up to 64 wide, plus degenerate and over-wide sizes.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
